// ----- hw/rtl/bmph_pkg.sv -----
// shared constants and types for the bar meter with peak hold
package bmph_pkg;

   // meter geometry
   localparam int unsigned SEG_W       = 6;
   localparam logic [SEG_W-1:0] TOP_SEGMENT = 6'd42;
   localparam int unsigned NUM_SEG     = 43;
   localparam int unsigned TIME_W      = 32;

   // configuration register widths and reset values
   localparam int unsigned INTERVAL_W  = 16;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd200;
   localparam logic [SEG_W-1:0]      GREEN_RESET    = 6'd18;
   localparam logic [NUM_SEG-1:0]    TALL_RESET     = 43'h44444455554;

   // configuration port
   localparam int unsigned DATA_W  = 64;
   localparam int unsigned ADDR_W  = 5;
   localparam int unsigned INDEX_W = 2;

   // register index codes
   localparam logic [INDEX_W-1:0] REG_DECAY_INTERVAL = 2'd0;
   localparam logic [INDEX_W-1:0] REG_GREEN_LIMIT    = 2'd1;
   localparam logic [INDEX_W-1:0] REG_TALL_MASK      = 2'd2;

   // pixel geometry of the redraws
   localparam int unsigned XPOS_W   = 9;
   localparam int unsigned YTOP_W   = 7;
   localparam int unsigned HEIGHT_W = 5;
   localparam logic [XPOS_W-1:0]   X_ORIGIN     = 9'd26;
   localparam logic [YTOP_W-1:0]   Y_TOP_TALL   = 7'd94;
   localparam logic [YTOP_W-1:0]   Y_TOP_NORMAL = 7'd98;
   localparam logic [HEIGHT_W-1:0] H_TALL       = 5'd22;
   localparam logic [HEIGHT_W-1:0] H_NORMAL     = 5'd18;

   // segment colors
   typedef enum logic [1:0] {
      COLOR_BACKGROUND = 2'd0,
      COLOR_PEAK       = 2'd1,
      COLOR_GREEN      = 2'd2,
      COLOR_RED        = 2'd3
   } color_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT
   } state_type;

endpackage

// ----- hw/rtl/bmph_req_if.sv -----
// input channel carrying meter updates
interface bmph_req_if;
   import bmph_pkg::*;

   logic              valid;
   logic              ready;
   logic [SEG_W-1:0]  new_level;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output new_level, output now_ms, input ready);
   modport sink   (input valid, input new_level, input now_ms, output ready);
endinterface

// ----- hw/rtl/bmph_rsp_if.sv -----
// result channel carrying segment redraws
interface bmph_rsp_if;
   import bmph_pkg::*;

   logic                valid;
   logic                ready;
   logic [SEG_W-1:0]    segment_index;
   logic [XPOS_W-1:0]   x_pos;
   logic [YTOP_W-1:0]   y_top;
   logic [HEIGHT_W-1:0] seg_height;
   logic [1:0]          color_code;
   logic                last;

   modport source (output valid, output segment_index, output x_pos, output y_top,
                   output seg_height, output color_code, output last, input ready);
   modport sink   (input valid, input segment_index, input x_pos, input y_top,
                   input seg_height, input color_code, input last, output ready);
endinterface

// ----- hw/rtl/bar_meter_peak_hold_top.sv -----
// bar meter with peak hold: update sequencer and segment redraw unit
//
// Each accepted update passes from acceptance to evaluation (ST_EVAL),
// where the level, peak and peak time are updated, and then one redraw
// leaves per cycle in which the result channel is ready, from the first
// changed segment up to segment 42 in ascending order, the final one
// flagged with last. An update yields 0 to 43 redraws; the single segment
// counter steps the shared redraw unit once per taken redraw. The input is
// not ready until the last redraw of an update has been taken.
// Configuration sits at byte addresses 0 (decay interval), 8 (green limit)
// and 16 (tall mask) of a 64-bit APB port and has no clearing pass.
module bar_meter_peak_hold_top (
   input  logic                          clock,
   input  logic                          reset,
   bmph_req_if.sink                      req_chan,
   bmph_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bmph_pkg::ADDR_W-1:0]   paddr,
   input  logic [bmph_pkg::DATA_W-1:0]   pwdata,
   output logic [bmph_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import bmph_pkg::*;

   // configuration registers
   logic [INTERVAL_W-1:0] decay_interval_ff;
   logic [SEG_W-1:0]      green_limit_ff;
   logic [NUM_SEG-1:0]    tall_mask_ff;
   logic [INDEX_W-1:0]    csr_index;
   logic                  csr_write;

   // meter state
   logic [SEG_W-1:0]  shown_level_ff, shown_level_in;
   logic [SEG_W-1:0]  peak_level_ff, peak_level_in;
   logic [TIME_W-1:0] peak_time_ff, peak_time_in;

   // sequencer and captured update
   state_type         state_ff, state_in;
   logic [SEG_W-1:0]  level_ff;
   logic [TIME_W-1:0] now_ff;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic              decay_mode_ff, decay_mode_in;

   // evaluation results
   logic              expired;
   logic              has_redraw;
   logic [SEG_W-1:0]  start_seg;
   logic [SEG_W-1:0]  peak_minus_one;
   logic [SEG_W-1:0]  sat_level;
   logic              req_fire;
   logic              rsp_fire;
   logic              at_top;

   // redraw unit signals
   logic              tall;
   color_type         color;

   assign pready    = 1'b1;
   assign csr_index = paddr[ADDR_W-1:ADDR_W-INDEX_W];
   assign csr_write = psel && penable && pwrite && pready;

   // register read back
   always_comb begin
      case (csr_index)
         REG_DECAY_INTERVAL: prdata = DATA_W'(decay_interval_ff);
         REG_GREEN_LIMIT:    prdata = DATA_W'(green_limit_ff);
         REG_TALL_MASK:      prdata = DATA_W'(tall_mask_ff);
         default:            prdata = '0;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_interval_ff <= INTERVAL_RESET;
         green_limit_ff    <= GREEN_RESET;
         tall_mask_ff      <= TALL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_DECAY_INTERVAL: decay_interval_ff <= pwdata[INTERVAL_W-1:0];
            REG_GREEN_LIMIT:    green_limit_ff    <= pwdata[SEG_W-1:0];
            REG_TALL_MASK:      tall_mask_ff      <= pwdata[NUM_SEG-1:0];
            default:            ;
         endcase
      end
   end

   // handshakes
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign at_top    = (seg_ff == TOP_SEGMENT);
   assign sat_level = (req_chan.new_level > TOP_SEGMENT) ? TOP_SEGMENT : req_chan.new_level;

   // decay timer compare
   assign expired        = (now_ff - peak_time_ff) > TIME_W'(decay_interval_ff);
   assign peak_minus_one = peak_level_ff - 1'b1;

   // update evaluation
   always_comb begin
      shown_level_in = shown_level_ff;
      peak_level_in  = peak_level_ff;
      peak_time_in   = peak_time_ff;
      start_seg      = shown_level_ff;
      has_redraw     = 1'b0;
      decay_mode_in  = decay_mode_ff;
      if (level_ff != shown_level_ff) begin
         has_redraw    = 1'b1;
         decay_mode_in = 1'b0;
         if (level_ff > shown_level_ff) begin
            shown_level_in = level_ff;
            peak_level_in  = level_ff;
            peak_time_in   = now_ff;
            start_seg      = shown_level_ff;
         end else begin
            if (expired) begin
               peak_level_in = (peak_level_ff == '0) ? '0 : peak_minus_one;
               peak_time_in  = now_ff;
            end
            shown_level_in = shown_level_ff - 1'b1;
            start_seg      = shown_level_ff - 1'b1;
         end
      end else if ((peak_level_ff > shown_level_ff) && expired) begin
         // steady level: expired peak steps down by two, or by one when that reaches zero
         if (peak_minus_one != '0) begin
            peak_level_in = peak_minus_one - 1'b1;
            peak_time_in  = now_ff;
            start_seg     = peak_minus_one - 1'b1;
            has_redraw    = 1'b1;
            decay_mode_in = 1'b1;
         end else begin
            peak_level_in = peak_minus_one;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_EVAL;
         ST_EVAL: state_in = has_redraw ? ST_EMIT : ST_IDLE;
         ST_EMIT: if (rsp_fire && at_top) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_EMIT: rsp_chan.valid = 1'b1;
         default: ;
      endcase
   end

   // segment counter
   always_comb begin
      seg_in = seg_ff;
      if (state_ff == ST_EVAL) begin
         seg_in = start_seg;
      end else if (rsp_fire && !at_top) begin
         seg_in = seg_ff + 1'b1;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         seg_ff         <= '0;
         decay_mode_ff  <= 1'b0;
         shown_level_ff <= '0;
         peak_level_ff  <= '0;
         peak_time_ff   <= '0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
         if (state_ff == ST_EVAL) begin
            decay_mode_ff  <= decay_mode_in;
            shown_level_ff <= shown_level_in;
            peak_level_ff  <= peak_level_in;
            peak_time_ff   <= peak_time_in;
         end
      end
   end

   // captured update payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         level_ff <= sat_level;
         now_ff   <= req_chan.now_ms;
      end
   end

   // redraw unit: color and geometry of the current segment
   assign tall = tall_mask_ff[seg_ff];

   always_comb begin
      if (!decay_mode_ff && (seg_ff < shown_level_ff)) begin
         color = (seg_ff <= green_limit_ff) ? COLOR_GREEN : COLOR_RED;
      end else begin
         color = (seg_ff == peak_level_ff) ? COLOR_PEAK : COLOR_BACKGROUND;
      end
   end

   assign rsp_chan.segment_index = seg_ff;
   assign rsp_chan.x_pos         = X_ORIGIN + (XPOS_W'(seg_ff) << 2) + (XPOS_W'(seg_ff) << 1);
   assign rsp_chan.y_top         = tall ? Y_TOP_TALL : Y_TOP_NORMAL;
   assign rsp_chan.seg_height    = tall ? H_TALL : H_NORMAL;
   assign rsp_chan.color_code    = color;
   assign rsp_chan.last          = at_top;

   // no new update is taken while redraws are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("update accepted while redraws pending");

   // redraws of one update come in ascending segment order
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_chan.last |=>
         rsp_chan.valid && (rsp_chan.segment_index == $past(rsp_chan.segment_index) + 1'b1))
      else $error("redraw sequence broken");

   // after the final redraw the block returns to taking updates
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_chan.last |=> req_chan.ready && !rsp_chan.valid)
      else $error("not idle after final redraw");

   // shown and peak levels never exceed the top segment
   assert property (@(posedge clock) disable iff (reset)
      shown_level_ff <= TOP_SEGMENT && peak_level_ff <= TOP_SEGMENT)
      else $error("level beyond top segment");

endmodule
